FILE: design/lte_pkg.sv
// Shared types and constants for the LED twinkle fade engine.
package lte_pkg;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FRAME_PERIOD    = 2'd0;
  localparam cfg_idx_t REG_BASE_HUE        = 2'd1;
  localparam cfg_idx_t REG_BASE_SATURATION = 2'd2;
  localparam cfg_idx_t REG_TWINKLE_DEPTH   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [6:0] FRAME_PERIOD_RST  = 7'd10;
  localparam logic [7:0] HUE_RST           = 8'd0;
  localparam logic [7:0] SATURATION_RST    = 8'd0;
  localparam logic [7:0] TWINKLE_DEPTH_RST = 8'd60;

  // Brightness of an LED that has never been changed.
  localparam logic [7:0] FULL_BRIGHT = 8'd255;

  // Queue depths (powers of two).
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  // Command from the front end to the back end.
  typedef struct packed {
    logic       tgt_we;
    logic [4:0] led;
    logic [7:0] target;
    logic       fade;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [4:0] led_index;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;
    logic       last_led;
  } res_t;

endpackage

FILE: design/lte_fifo.sv
// Small synchronous queue used between the engine's stages.
module lte_fifo
  import lte_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     level
);

  localparam int PW    = $clog2(DEPTH);
  localparam int LVL_W = PW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [LVL_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == LVL_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign level   = count_r;
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

endmodule

FILE: design/lte_front.sv
// Front end: frame and fade counters, target clamp, command generation.
module lte_front
  import lte_pkg::*;
#(
  parameter int LED_COUNT   = 32,
  parameter int FADE_PERIOD = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [4:0] in_random_led,
  input  logic [7:0] in_random_dim,
  input  logic [6:0] frame_period,
  input  logic [7:0] twinkle_depth,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [6:0] frame_count_r, frame_count_nxt;
  logic [1:0] fade_count_r, fade_count_nxt;
  logic       accept;
  logic [7:0] fc;
  logic [2:0] dc;
  logic       frame_fire;
  logic       fade_fire;
  logic       led_ok;
  logic [7:0] depth_m1;
  logic [7:0] dim_c;

  assign accept = in_push && !q_full;

  // Counters compare on the incremented value; a firing counter clears.
  always_comb begin
    fc              = {1'b0, frame_count_r} + 8'd1;
    dc              = {1'b0, fade_count_r} + 3'd1;
    frame_fire      = (fc > {1'b0, frame_period});
    fade_fire       = (dc > 3'(FADE_PERIOD));
    frame_count_nxt = frame_fire ? 7'd0 : fc[6:0];
    fade_count_nxt  = fade_fire ? 2'd0 : dc[1:0];
  end

  // Clamp the dim amount below the twinkle depth.
  always_comb begin
    depth_m1 = twinkle_depth - 8'd1;
    if (twinkle_depth == 8'd0) begin
      dim_c = 8'd0;
    end else if (in_random_dim > depth_m1) begin
      dim_c = depth_m1;
    end else begin
      dim_c = in_random_dim;
    end
    led_ok = ({2'b00, in_random_led} < 7'(LED_COUNT));
  end

  // Build the command; frames that change nothing are dropped here.
  always_comb begin
    q_cmd.tgt_we = frame_fire && led_ok;
    q_cmd.led    = in_random_led;
    q_cmd.target = FULL_BRIGHT - dim_c;
    q_cmd.fade   = fade_fire;
    q_push       = accept && (q_cmd.tgt_we || fade_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      fade_count_r  <= '0;
    end else if (accept) begin
      frame_count_r <= frame_count_nxt;
      fade_count_r  <= fade_count_nxt;
    end
  end

endmodule

FILE: design/lte_back.sv
// Back end: target writes and the per-LED fade sweep.
module lte_back
  import lte_pkg::*;
#(
  parameter int LED_COUNT = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  cmd_t                         q_cmd,
  output logic                         q_pop,
  input  logic [7:0]                   base_hue,
  input  logic [7:0]                   base_saturation,
  input  logic [$clog2(OUTQ_DEPTH):0]  oq_level,
  output logic                         oq_push,
  output res_t                         oq_res
);

  localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LVL_W  = $clog2(OUTQ_DEPTH) + 1;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(LED_COUNT - 1);

  typedef enum logic {ST_IDLE, ST_SWEEP} state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   idx_r;
  logic                s1_r;
  logic [ADDR_W-1:0]   s1_idx_r;
  logic [LED_COUNT-1:0] tvld_r;
  logic [LED_COUNT-1:0] cvld_r;
  logic                tvld_rd_r;
  logic                cvld_rd_r;
  logic [7:0]          tgt_rd_r;
  logic [7:0]          cur_rd_r;
  logic [7:0]          tgt_mem [LED_COUNT];
  logic [7:0]          cur_mem [LED_COUNT];

  logic                tgt_we;
  logic [ADDR_W-1:0]   tgt_addr;
  logic                space;
  logic                rd_en;
  logic [7:0]          cur_c;
  logic [7:0]          tgt_c;
  logic [7:0]          cur_new;
  logic [6:0]          idx_ext;

  // Issue side: pop commands while idle, read one LED a cycle while sweeping and the output queue has space.
  always_comb begin
    q_pop    = (state_r == ST_IDLE) && !q_empty;
    tgt_we   = q_pop && q_cmd.tgt_we;
    tgt_addr = ADDR_W'({2'b00, q_cmd.led});
    space    = ((LVL_W + 1)'(oq_level) + (LVL_W + 1)'(s1_r)) < (LVL_W + 1)'(OUTQ_DEPTH);
    rd_en    = (state_r == ST_SWEEP) && space;
  end

  // Step stage: move the current brightness one toward the target.
  always_comb begin
    cur_c = cvld_rd_r ? cur_rd_r : FULL_BRIGHT;
    tgt_c = tvld_rd_r ? tgt_rd_r : FULL_BRIGHT;
    if (cur_c < tgt_c) begin
      cur_new = cur_c + 8'd1;
    end else if (cur_c > tgt_c) begin
      cur_new = cur_c - 8'd1;
    end else begin
      cur_new = cur_c;
    end
    idx_ext           = 7'(s1_idx_r);
    oq_push           = s1_r;
    oq_res.led_index  = idx_ext[4:0];
    oq_res.hue        = base_hue;
    oq_res.saturation = base_saturation;
    oq_res.value      = cur_new;
    oq_res.last_led   = (s1_idx_r == LAST_IDX);
  end

  // Sequencer state and entry valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s1_r    <= 1'b0;
      tvld_r  <= '0;
      cvld_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_pop && q_cmd.fade) begin
            state_r <= ST_SWEEP;
            idx_r   <= '0;
          end
        end
        ST_SWEEP: begin
          if (rd_en) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == LAST_IDX) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      s1_r <= rd_en;
      if (rd_en) begin
        s1_idx_r  <= idx_r;
        tvld_rd_r <= tvld_r[idx_r];
        cvld_rd_r <= cvld_r[idx_r];
      end
      if (tgt_we) tvld_r[tgt_addr] <= 1'b1;
      if (s1_r) cvld_r[s1_idx_r] <= 1'b1;
    end
  end

  // Target brightness memory.
  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[tgt_addr] <= q_cmd.target;
    if (rd_en) tgt_rd_r <= tgt_mem[idx_r];
  end

  // Current brightness memory.
  always_ff @(posedge clk) begin
    if (s1_r) cur_mem[s1_idx_r] <= cur_new;
    if (rd_en) cur_rd_r <= cur_mem[idx_r];
  end

endmodule

FILE: design/led_twinkle_fade_engine.sv
// Top level of the LED twinkle fade engine.
//
//   channel  direction  handshake         words
//   in_      input      in_push/in_full   one frame tick
//   out_     output     out_pop/out_empty one LED color per word
//   cfg_     input      cfg_we            one register write
//
// A frame tick that changes nothing is dropped in the front end; a fade frame
// sweeps the brightness memories one LED per cycle while the output queue has
// space, paced by the single read port of each memory and the output queue.
// Reset is synchronous; brightness entries read as 255 until first written.
// A stalled output fills the output queue, then the command queue, and then
// raises in_full.
module led_twinkle_fade_engine
  import lte_pkg::*;
#(
  parameter int LED_COUNT   = 32,
  parameter int FADE_PERIOD = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [4:0] in_random_led,
  input  logic [7:0] in_random_dim,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [4:0] out_led_index,
  output logic [7:0] out_hue,
  output logic [7:0] out_saturation,
  output logic [7:0] out_value,
  output logic       out_last_led,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  logic [7:0] cfg_data
);

  logic [6:0] frame_period_r;
  logic [7:0] base_hue_r;
  logic [7:0] base_saturation_r;
  logic [7:0] twinkle_depth_r;

  logic       cq_push;
  cmd_t       cq_wcmd;
  cmd_t       cq_rcmd;
  logic       cq_full;
  logic       cq_empty;
  logic       cq_pop;

  logic       oq_push;
  res_t       oq_wres;
  res_t       oq_rres;
  logic [$clog2(OUTQ_DEPTH):0] oq_level;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r    <= FRAME_PERIOD_RST;
      base_hue_r        <= HUE_RST;
      base_saturation_r <= SATURATION_RST;
      twinkle_depth_r   <= TWINKLE_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_PERIOD:    frame_period_r    <= cfg_data[6:0];
        REG_BASE_HUE:        base_hue_r        <= cfg_data;
        REG_BASE_SATURATION: base_saturation_r <= cfg_data;
        REG_TWINKLE_DEPTH:   twinkle_depth_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_full = cq_full;

  lte_front #(
    .LED_COUNT   (LED_COUNT),
    .FADE_PERIOD (FADE_PERIOD)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_random_led (in_random_led),
    .in_random_dim (in_random_dim),
    .frame_period  (frame_period_r),
    .twinkle_depth (twinkle_depth_r),
    .q_full        (cq_full),
    .q_push        (cq_push),
    .q_cmd         (cq_wcmd)
  );

  // Command queue between the front and back ends.
  lte_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wcmd),
    .pop   (cq_pop),
    .rdata (cq_rcmd),
    .full  (cq_full),
    .empty (cq_empty),
    .level ()
  );

  lte_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (cq_empty),
    .q_cmd           (cq_rcmd),
    .q_pop           (cq_pop),
    .base_hue        (base_hue_r),
    .base_saturation (base_saturation_r),
    .oq_level        (oq_level),
    .oq_push         (oq_push),
    .oq_res          (oq_wres)
  );

  // Output queue holding result words.
  lte_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wres),
    .pop   (out_pop),
    .rdata (oq_rres),
    .full  (),
    .empty (out_empty),
    .level (oq_level)
  );

  assign out_led_index  = oq_rres.led_index;
  assign out_hue        = oq_rres.hue;
  assign out_saturation = oq_rres.saturation;
  assign out_value      = oq_rres.value;
  assign out_last_led   = oq_rres.last_led;

endmodule
